### rtl/core/stsd_pkg.sv
// Shared types and constants for the sequential turn signal driver.
package stsd_pkg;

  localparam int SEGMENT_COUNT = 4;
  localparam int DRIVE_W       = 4;
  localparam int PHASE_W       = $clog2(SEGMENT_COUNT + 1);
  localparam int LONG_W        = 20;
  localparam int SHORT_W       = 16;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;
  localparam int REG_IDX_W     = 3;

  localparam logic [LONG_W-1:0] IDLE_MAX = {LONG_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_SWEEP = 2'd0,
    MODE_SEQ   = 2'd1,
    MODE_DARK  = 2'd2,
    MODE_MARK  = 2'd3
  } mode_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FILL_STEP    = 3'd0,
    REG_DARK_GAP     = 3'd1,
    REG_SWEEP_STEP   = 3'd2,
    REG_IDLE_TIMEOUT = 3'd3,
    REG_MARKER_ON    = 3'd4,
    REG_MARKER_OFF   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [LONG_W-1:0]  fill_step_ticks;
    logic [LONG_W-1:0]  dark_gap_ticks;
    logic [LONG_W-1:0]  sweep_step_ticks;
    logic [LONG_W-1:0]  idle_timeout_ticks;
    logic [SHORT_W-1:0] marker_on_ticks;
    logic [SHORT_W-1:0] marker_off_ticks;
  } cfg_t;

endpackage

### rtl/core/stsd_regs.sv
// APB configuration registers of the turn signal driver.
module stsd_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stsd_pkg::ADDR_W-1:0]   paddr,
  input  logic [stsd_pkg::DATA_W-1:0]   pwdata,
  output logic [stsd_pkg::DATA_W-1:0]   prdata,
  output stsd_pkg::cfg_t                cfg_o
);

  stsd_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [stsd_pkg::REG_IDX_W-1:0] idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = paddr[stsd_pkg::ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fill_step_ticks    <= stsd_pkg::LONG_W'(25000);
      cfg_q.dark_gap_ticks     <= stsd_pkg::LONG_W'(25000);
      cfg_q.sweep_step_ticks   <= stsd_pkg::LONG_W'(32500);
      cfg_q.idle_timeout_ticks <= stsd_pkg::LONG_W'(147456);
      cfg_q.marker_on_ticks    <= stsd_pkg::SHORT_W'(10);
      cfg_q.marker_off_ticks   <= stsd_pkg::SHORT_W'(100);
    end else if (wr_en) begin
      unique case (idx)
        stsd_pkg::REG_FILL_STEP:
          cfg_q.fill_step_ticks <= pwdata[stsd_pkg::LONG_W-1:0];
        stsd_pkg::REG_DARK_GAP:
          cfg_q.dark_gap_ticks <= pwdata[stsd_pkg::LONG_W-1:0];
        stsd_pkg::REG_SWEEP_STEP:
          cfg_q.sweep_step_ticks <= pwdata[stsd_pkg::LONG_W-1:0];
        stsd_pkg::REG_IDLE_TIMEOUT:
          cfg_q.idle_timeout_ticks <= pwdata[stsd_pkg::LONG_W-1:0];
        stsd_pkg::REG_MARKER_ON:
          cfg_q.marker_on_ticks <= pwdata[stsd_pkg::SHORT_W-1:0];
        stsd_pkg::REG_MARKER_OFF:
          cfg_q.marker_off_ticks <= pwdata[stsd_pkg::SHORT_W-1:0];
        default: ;  // unmapped, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      stsd_pkg::REG_FILL_STEP:    prdata = stsd_pkg::DATA_W'(cfg_q.fill_step_ticks);
      stsd_pkg::REG_DARK_GAP:     prdata = stsd_pkg::DATA_W'(cfg_q.dark_gap_ticks);
      stsd_pkg::REG_SWEEP_STEP:   prdata = stsd_pkg::DATA_W'(cfg_q.sweep_step_ticks);
      stsd_pkg::REG_IDLE_TIMEOUT: prdata = stsd_pkg::DATA_W'(cfg_q.idle_timeout_ticks);
      stsd_pkg::REG_MARKER_ON:    prdata = stsd_pkg::DATA_W'(cfg_q.marker_on_ticks);
      stsd_pkg::REG_MARKER_OFF:   prdata = stsd_pkg::DATA_W'(cfg_q.marker_off_ticks);
      default:                    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/stsd_core.sv
// Mode/phase state and per-tick next-state and segment logic.
module stsd_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  stsd_pkg::cfg_t                cfg_i,
  input  logic                          tick_i,
  input  logic                          req_i,
  output logic [stsd_pkg::DRIVE_W-1:0]  drive_o,
  output stsd_pkg::mode_e               mode_o
);

  localparam int PW = stsd_pkg::PHASE_W;
  localparam int LW = stsd_pkg::LONG_W;
  localparam int SW = stsd_pkg::SHORT_W;

  stsd_pkg::mode_e mode_q, mode_d, mode_c;
  logic [PW-1:0]   phase_q, phase_d, phase_c, phase_inc;
  logic [LW-1:0]   pt_q, pt_d, pt_c;
  logic [LW-1:0]   idle_q, idle_d, idle_c;
  logic [SW-1:0]   pu_q, pu_d, pu_c;
  logic [LW-1:0]   step_len, step_fix;
  logic [LW:0]     pt_inc;
  logic            step_done;
  logic [SW-1:0]   pulse_len, pulse_fix;
  logic [SW:0]     pu_inc;
  logic            pulse_done;
  logic            fill_active;
  logic [stsd_pkg::DRIVE_W-1:0] drive;

  always_comb begin
    // run start / marker entry decision
    mode_c  = mode_q;
    phase_c = phase_q;
    pt_c    = pt_q;
    idle_c  = idle_q;
    pu_c    = pu_q;
    if (mode_q == stsd_pkg::MODE_DARK ||
        (mode_q == stsd_pkg::MODE_MARK && phase_q == '0 && pu_q == '0)) begin
      if (req_i) begin
        mode_c  = stsd_pkg::MODE_SEQ;
        phase_c = '0;
        pt_c    = '0;
        idle_c  = '0;
      end else if (mode_q == stsd_pkg::MODE_DARK &&
                   idle_q >= cfg_i.idle_timeout_ticks) begin
        mode_c  = stsd_pkg::MODE_MARK;
        phase_c = '0;
        pu_c    = '0;
      end
    end
  end

  assign fill_active = phase_c < PW'(stsd_pkg::SEGMENT_COUNT);
  assign phase_inc   = phase_c + PW'(1);

  always_comb begin
    if (mode_c == stsd_pkg::MODE_SWEEP) begin
      step_len = cfg_i.sweep_step_ticks;
    end else if (fill_active) begin
      step_len = cfg_i.fill_step_ticks;
    end else begin
      step_len = cfg_i.dark_gap_ticks;
    end
    pulse_len = (phase_c == '0) ? cfg_i.marker_on_ticks : cfg_i.marker_off_ticks;
  end

  // a zero length acts as one tick
  assign step_fix   = (step_len == '0) ? LW'(1) : step_len;
  assign pulse_fix  = (pulse_len == '0) ? SW'(1) : pulse_len;
  assign pt_inc     = {1'b0, pt_c} + (LW+1)'(1);
  assign pu_inc     = {1'b0, pu_c} + (SW+1)'(1);
  assign step_done  = pt_inc >= {1'b0, step_fix};
  assign pulse_done = pu_inc >= {1'b0, pulse_fix};

  always_comb begin
    mode_d  = mode_c;
    phase_d = phase_c;
    pt_d    = pt_c;
    pu_d    = pu_c;
    drive   = '0;
    unique case (mode_c)
      stsd_pkg::MODE_SWEEP: begin
        for (int i = 0; i < stsd_pkg::DRIVE_W; i++) begin
          drive[i] = (i < stsd_pkg::SEGMENT_COUNT) && (phase_c == PW'(i));
        end
        pt_d = step_done ? '0 : pt_inc[LW-1:0];
        if (step_done) begin
          if (phase_inc >= PW'(stsd_pkg::SEGMENT_COUNT)) begin
            mode_d  = stsd_pkg::MODE_DARK;
            phase_d = '0;
          end else begin
            phase_d = phase_inc;
          end
        end
      end
      stsd_pkg::MODE_SEQ: begin
        pt_d = step_done ? '0 : pt_inc[LW-1:0];
        if (fill_active) begin
          for (int i = 0; i < stsd_pkg::DRIVE_W; i++) begin
            drive[i] = (i < stsd_pkg::SEGMENT_COUNT) && (PW'(i) <= phase_c);
          end
          if (step_done) begin
            phase_d = phase_inc;
          end
        end else if (step_done) begin
          mode_d  = stsd_pkg::MODE_DARK;
          phase_d = '0;
        end
      end
      stsd_pkg::MODE_MARK: begin
        pu_d = pulse_done ? '0 : pu_inc[SW-1:0];
        if (phase_c == '0) begin
          for (int i = 0; i < stsd_pkg::DRIVE_W; i++) begin
            drive[i] = (i < stsd_pkg::SEGMENT_COUNT);
          end
          if (pulse_done) begin
            phase_d = PW'(1);
          end
        end else if (pulse_done) begin
          phase_d = '0;
        end
      end
      default: ;  // dark wait: all off, step and pulse timers hold, idle timer counts
    endcase
    idle_d = (idle_c != stsd_pkg::IDLE_MAX) ? idle_c + LW'(1) : idle_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= stsd_pkg::MODE_SWEEP;
      phase_q <= '0;
      pt_q    <= '0;
      idle_q  <= '0;
      pu_q    <= '0;
    end else if (tick_i) begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      pt_q    <= pt_d;
      idle_q  <= idle_d;
      pu_q    <= pu_d;
    end
  end

  assign drive_o = drive;
  assign mode_o  = mode_c;

endmodule

### rtl/core/sequential_turn_signal_driver.sv
// Top level: sequential turn signal driver with APB config and result register.
// Latency: an accepted input beat's result is registered and shows on the outputs in the next cycle.
// Throughput: one beat per cycle; one pass of logic from state into the result register.
// Input is stalled only while a finished result beat waits on a stalled output.
// Reset (rst_ni low, async): power-on sweep from segment 1, all timers zero,
//   config registers at their defaults, no result beat pending.
module sequential_turn_signal_driver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stsd_pkg::ADDR_W-1:0]   paddr,
  input  logic [stsd_pkg::DATA_W-1:0]   pwdata,
  output logic [stsd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // tick input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          signal_request_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [3:0]                    segment_drive_o,
  output logic [1:0]                    mode_now_o
);

  stsd_pkg::cfg_t                  cfg;
  logic                            in_beat;
  logic [stsd_pkg::DRIVE_W-1:0]    drive;
  stsd_pkg::mode_e                 mode;

  logic                            out_valid_q, out_valid_d;
  logic [stsd_pkg::DRIVE_W-1:0]    drive_q;
  logic [1:0]                      mode_q;

  assign pready = 1'b1;

  stsd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // Stall the input only when the result register is full and not draining.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_beat    = in_valid_i & ~in_stall_o;

  // Core advances its state only on an accepted tick beat.
  stsd_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .tick_i  (in_beat),
    .req_i   (signal_request_i),
    .drive_o (drive),
    .mode_o  (mode)
  );

  // Result register: loads on each accepted beat, empties when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_beat) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      drive_q <= drive;
      mode_q  <= mode;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign segment_drive_o = drive_q;
  assign mode_now_o      = mode_q;

`ifndef NO_ASSERTIONS
  // every accepted tick produces a result beat on the next cycle
  a_beat_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted tick without result beat");

  // dark wait keeps every segment off
  a_dark_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_now_o == stsd_pkg::MODE_DARK |-> segment_drive_o == '0)
    else $error("segments lit in dark wait");

  // sweep lights at most one segment at a time
  a_sweep_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_now_o == stsd_pkg::MODE_SWEEP |-> $onehot0(segment_drive_o))
    else $error("sweep lit more than one segment");

  // a result beat waiting on a stalled output is not overwritten
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(segment_drive_o)
      && $stable(mode_now_o))
    else $error("pending result beat changed");
`endif

endmodule
